@@ design/chta_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// chta_pkg: shared types and codes of the callsign hash table
// Slot layout, command, hash kind and status codes, probe arithmetic constants.
// ----------------------------------------------------------------------------
package chta_pkg;

	// one table slot as stored in the slot memory
	typedef struct packed {
		logic [47:0] head;
		logic [39:0] tail;
		logic [21:0] hash;
		logic [7:0]  age;
	} slot_t;

	// commands
	localparam logic [1:0] CMD_ADD    = 2'd0;
	localparam logic [1:0] CMD_LOOKUP = 2'd1;
	localparam logic [1:0] CMD_AGE    = 2'd2;

	// lookup hash kinds
	localparam logic [1:0] KIND_H22 = 2'd0;
	localparam logic [1:0] KIND_H12 = 2'd1;
	localparam logic [1:0] KIND_H10 = 2'd2;

	// result status codes
	localparam logic [2:0] STAT_INSERTED  = 3'd0;
	localparam logic [2:0] STAT_REFRESHED = 3'd1;
	localparam logic [2:0] STAT_FOUND     = 3'd2;
	localparam logic [2:0] STAT_NOT_FOUND = 3'd3;
	localparam logic [2:0] STAT_FULL      = 3'd4;
	localparam logic [2:0] STAT_EMPTY     = 3'd5;

	// start slot arithmetic: top ten hash bits times 23, fits 15 bits
	localparam int HASH_MULT = 23;
	localparam int PROD_W    = 15;

	// max_age after reset
	localparam logic [7:0] MAX_AGE_RESET = 8'd10;

endpackage : chta_pkg
`default_nettype wire

@@ design/chta_slot_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// chta_slot_ram: slot memory of the callsign hash table
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module chta_slot_ram #(
	parameter int DEPTH = 256,
	parameter int AW    = 8
) (
	input  wire logic            clk,
	input  wire logic            we,
	input  wire logic [AW-1:0]   waddr,
	input  wire chta_pkg::slot_t wdata,
	input  wire logic [AW-1:0]   raddr,
	output      chta_pkg::slot_t rdata
);
	import chta_pkg::*;

	slot_t mem_q [DEPTH];
	slot_t rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule : chta_slot_ram
`default_nettype wire

@@ design/callsign_hash_table_with_aging_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// callsign_hash_table_with_aging_unit: open-addressed callsign table with aging
// Linear-probe add / lookup and a full-table age sweep over a slot memory.
// ----------------------------------------------------------------------------
// After reset the block sweeps the slot memory once to clear it, with busy
// high. One word is taken when start is high and busy is low; each word
// gives exactly one result, shown for one cycle with done high, and the
// receiver has to take it then. Add and lookup pass through the shared
// reciprocal multiplier that reduces (top hash bits * 23) modulo TABLE_SIZE
// (states S_MOD, then S_REM), then one memory read and one check per probed
// slot, up to TABLE_SIZE slots. An age word sweeps every slot with one read
// and one check each. An empty callsign on an add or an unused command
// answers at once, with done high in the cycle right after the accept. The
// single memory read port is why each slot needs a read before its check.
module callsign_hash_table_with_aging_unit #(
	parameter int TABLE_SIZE = 256
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output      logic        busy,
	input  wire logic [1:0]  cmd,
	input  wire logic [1:0]  hash_kind,
	input  wire logic [21:0] hash_value,
	input  wire logic [47:0] callsign_head,
	input  wire logic [39:0] callsign_tail,
	input  wire logic        cfg_we,
	input  wire logic [7:0]  cfg_wdata,
	output      logic        done,
	output      logic [2:0]  status,
	output      logic [47:0] found_head,
	output      logic [39:0] found_tail,
	output      logic [8:0]  entry_total
);
	import chta_pkg::*;

	localparam int AW = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
	localparam int NW = $clog2(TABLE_SIZE + 1);
	localparam int CW = (NW > 9) ? NW : 9;
	localparam int RECIP_SH = PROD_W + AW;
	localparam int RW = PROD_W + 1;
	localparam int MW = 2 * PROD_W + 2;
	localparam longint RECIP_L =
		((longint'(1) << RECIP_SH) + longint'(TABLE_SIZE) - 1) / longint'(TABLE_SIZE);
	localparam logic [RW-1:0]     RECIP_M    = RW'(RECIP_L);
	localparam logic [PROD_W-1:0] SIZE_C     = PROD_W'(TABLE_SIZE);
	localparam logic [AW-1:0]     LAST_SLOT  = AW'(TABLE_SIZE - 1);
	localparam logic [NW-1:0]     LAST_PROBE = NW'(TABLE_SIZE - 1);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_MOD,
		S_REM,
		S_READ,
		S_CHECK,
		S_AGE_READ,
		S_AGE_CHECK
	} state_t;

	state_t              state_q;
	logic [AW-1:0]       slot_q;
	logic [NW-1:0]       probe_q;
	logic [PROD_W-1:0]   quot_q;
	logic [PROD_W-1:0]   rem_q;
	logic                is_add_q;
	logic [1:0]          kind_q;
	logic [21:0]         hash_q;
	logic [47:0]         head_q;
	logic [39:0]         tail_q;
	logic [CW-1:0]       cnt_q;
	logic [7:0]          max_age_q;
	logic                done_q;
	logic [2:0]          status_q;
	logic [47:0]         fhead_q;
	logic [39:0]         ftail_q;

	slot_t               rd;
	logic                mem_we;
	slot_t               mem_wdata;

	logic [47:0]         norm_head;
	logic [39:0]         norm_tail;
	logic [9:0]          top10;
	logic [PROD_W-1:0]   prod;
	logic [MW-1:0]       recip_prod;
	logic [PROD_W-1:0]   quot_next;
	logic [PROD_W-1:0]   rem_next;
	logic                rd_used;
	logic [21:0]         hash_sh;
	logic                add_match;
	logic                look_match;
	logic [AW-1:0]       slot_inc;

	// zero every character after the first zero character
	function automatic logic [87:0] normalize(input logic [87:0] txt);
		logic [87:0] res;
		logic        ended;
		res   = txt;
		ended = 1'b0;
		for (int i = 0; i < 11; i++) begin
			if (ended) begin
				res[87 - 8 * i -: 8] = 8'd0;
			end else if (txt[87 - 8 * i -: 8] == 8'd0) begin
				ended = 1'b1;
			end
		end
		return res;
	endfunction

	// callsign cleanup and start slot product at accept
	always_comb begin
		{norm_head, norm_tail} = normalize({callsign_head, callsign_tail});
		case (hash_kind)
			KIND_H10: top10 = hash_value[9:0];
			KIND_H12: top10 = hash_value[11:2];
			default:  top10 = hash_value[21:12];
		endcase
		if (cmd == CMD_ADD) begin
			top10 = hash_value[21:12];
		end
		prod = PROD_W'(top10) * PROD_W'(HASH_MULT);
	end

	// shared reciprocal multiplier: quotient, then remainder modulo TABLE_SIZE
	always_comb begin
		recip_prod = MW'(rem_q) * MW'(RECIP_M);
		quot_next  = PROD_W'(recip_prod >> RECIP_SH);
		rem_next   = rem_q - quot_q * SIZE_C;
	end

	// slot compare against the registered read word
	always_comb begin
		rd_used = rd.head[47:40] != 8'd0;
		case (kind_q)
			KIND_H10: hash_sh = rd.hash >> 12;
			KIND_H12: hash_sh = rd.hash >> 10;
			default:  hash_sh = rd.hash;
		endcase
		add_match  = (rd.hash == hash_q) && (rd.head == head_q) && (rd.tail == tail_q);
		look_match = hash_sh == hash_q;
		slot_inc   = (slot_q == LAST_SLOT) ? '0 : slot_q + 1'b1;
	end

	// memory write: clear sweep, insert, refresh and aging
	always_comb begin
		mem_we    = 1'b0;
		mem_wdata = '0;
		case (state_q)
			S_CLEAR: begin
				mem_we = 1'b1;
			end
			S_CHECK: begin
				if (is_add_q && !rd_used) begin
					mem_we    = 1'b1;
					mem_wdata = '{head: head_q, tail: tail_q, hash: hash_q, age: 8'd0};
				end else if (is_add_q && add_match) begin
					mem_we        = 1'b1;
					mem_wdata     = rd;
					mem_wdata.age = 8'd0;
				end
			end
			S_AGE_CHECK: begin
				if (rd_used) begin
					mem_we = 1'b1;
					if (rd.age <= max_age_q) begin
						mem_wdata     = rd;
						mem_wdata.age = rd.age + 8'd1;
					end
				end
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	chta_slot_ram #(
		.DEPTH (TABLE_SIZE),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (slot_q),
		.wdata (mem_wdata),
		.raddr (slot_q),
		.rdata (rd)
	);

	// sequencer, counters and registered result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			slot_q    <= '0;
			probe_q   <= '0;
			quot_q    <= '0;
			rem_q     <= '0;
			is_add_q  <= 1'b0;
			kind_q    <= KIND_H22;
			hash_q    <= '0;
			head_q    <= '0;
			tail_q    <= '0;
			cnt_q     <= '0;
			max_age_q <= MAX_AGE_RESET;
			done_q    <= 1'b0;
			status_q  <= STAT_INSERTED;
			fhead_q   <= '0;
			ftail_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (cfg_we) begin
				max_age_q <= cfg_wdata;
			end
			case (state_q)
				S_CLEAR: begin
					slot_q <= slot_inc;
					if (slot_q == LAST_SLOT) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						is_add_q <= cmd == CMD_ADD;
						kind_q   <= hash_kind;
						hash_q   <= hash_value;
						head_q   <= norm_head;
						tail_q   <= norm_tail;
						rem_q    <= prod;
						probe_q  <= '0;
						fhead_q  <= '0;
						ftail_q  <= '0;
						case (cmd)
							CMD_ADD: begin
								if (norm_head[47:40] == 8'd0) begin
									done_q   <= 1'b1;
									status_q <= STAT_EMPTY;
								end else begin
									state_q <= S_MOD;
								end
							end
							CMD_LOOKUP: begin
								state_q <= S_MOD;
							end
							CMD_AGE: begin
								slot_q  <= '0;
								state_q <= S_AGE_READ;
							end
							default: begin
								done_q   <= 1'b1;
								status_q <= STAT_NOT_FOUND;
							end
						endcase
					end
				end
				S_MOD: begin
					quot_q  <= quot_next;
					state_q <= S_REM;
				end
				S_REM: begin
					slot_q  <= rem_next[AW-1:0];
					state_q <= S_READ;
				end
				S_READ: begin
					state_q <= S_CHECK;
				end
				S_CHECK: begin
					if (!rd_used) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
						if (is_add_q) begin
							cnt_q    <= cnt_q + 1'b1;
							status_q <= STAT_INSERTED;
						end else begin
							status_q <= STAT_NOT_FOUND;
						end
					end else if (is_add_q && add_match) begin
						done_q   <= 1'b1;
						status_q <= STAT_REFRESHED;
						state_q  <= S_IDLE;
					end else if (!is_add_q && look_match) begin
						done_q   <= 1'b1;
						status_q <= STAT_FOUND;
						fhead_q  <= rd.head;
						ftail_q  <= rd.tail;
						state_q  <= S_IDLE;
					end else if (probe_q == LAST_PROBE) begin
						done_q   <= 1'b1;
						status_q <= is_add_q ? STAT_FULL : STAT_NOT_FOUND;
						state_q  <= S_IDLE;
					end else begin
						probe_q <= probe_q + 1'b1;
						slot_q  <= slot_inc;
						state_q <= S_READ;
					end
				end
				S_AGE_READ: begin
					state_q <= S_AGE_CHECK;
				end
				S_AGE_CHECK: begin
					if (rd_used && (rd.age > max_age_q)) begin
						cnt_q <= cnt_q - 1'b1;
					end
					slot_q <= slot_inc;
					if (slot_q == LAST_SLOT) begin
						done_q   <= 1'b1;
						status_q <= STAT_INSERTED;
						state_q  <= S_IDLE;
					end else begin
						state_q <= S_AGE_READ;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy        = state_q != S_IDLE;
	assign done        = done_q;
	assign status      = status_q;
	assign found_head  = fhead_q;
	assign found_tail  = ftail_q;
	assign entry_total = cnt_q[8:0];

	// occupancy never exceeds the table
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(TABLE_SIZE))
		else $error("occupied count above table size");

	// an accepted word either starts work or answers at once
	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy || done))
		else $error("accepted word dropped");

	// the table is only written while a word is in progress or being cleared
	a_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> busy)
		else $error("slot write while idle");

	// callsign fields are zero unless a lookup found an entry
	a_found_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status != STAT_FOUND)) |-> ((found_head == '0) && (found_tail == '0)))
		else $error("callsign fields set without a match");

	// a found entry is always occupied
	a_found_used: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status == STAT_FOUND)) |-> (found_head[47:40] != 8'd0))
		else $error("found an empty slot");

endmodule : callsign_hash_table_with_aging_unit
`default_nettype wire
